// ===== sv/hwb_pkg.sv =====
// ----------------------------------------------------------------------------
// hwb_pkg
// Shared constants and types for the histogram white balance block.
// ----------------------------------------------------------------------------
`default_nettype none

package hwb_pkg;

    localparam int unsigned MAX_PIXELS = 524288;
    localparam int CNT_W   = $clog2(MAX_PIXELS + 1);
    localparam int PIX_W   = 8;
    localparam int BINS    = 256;
    localparam int BIN_W   = $clog2(BINS);
    localparam int RATIO_W = 15;
    localparam int SCALE_W = 17;
    localparam int THR_W   = CNT_W + SCALE_W;
    localparam int NCH     = 3;

    localparam logic [CNT_W-1:0]   MAX_COUNT = CNT_W'(MAX_PIXELS);
    localparam logic [RATIO_W-1:0] RATIO_RST = 15'd3277;
    localparam logic [SCALE_W-1:0] ONE_Q16   = 17'h10000;
    localparam logic [PIX_W-1:0]   PIX_MAX   = 8'd255;
    localparam logic [BIN_W-1:0]   LAST_BIN  = BIN_W'(BINS - 1);

    typedef struct packed {
        logic clear;
        logic step;
        logic gate_lo;
    } t_cut_ctl;

    typedef struct packed {
        logic       start;
        logic       step;
        logic [2:0] shift;
    } t_div_ctl;

endpackage

`default_nettype wire

// ===== sv/histogram_white_balance.sv =====
// ----------------------------------------------------------------------------
// histogram_white_balance
// Per-channel histogram stretch white balance for 8-bit BGR pixels.
// ----------------------------------------------------------------------------
// After reset the block clears the histogram RAMs and takes no pixel until
// then. An accumulate pixel does one RAM read and, while the frame holds
// fewer than MAX_PIXELS, one write-back of the incremented bin. One with
// frame_end adds one threshold multiply and a scan of one bin per cycle
// for all three channels at once, while the bins are zeroed behind the scan.
// A correct pixel runs through the 8-step serial divider that produces one
// quotient bit per cycle; its result waits in an output register so the
// next pixel can start while it is held.
`default_nettype none

module histogram_white_balance (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [hwb_pkg::RATIO_W-1:0] i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_opcode,
    input  wire logic [hwb_pkg::PIX_W-1:0]   i_blue_in,
    input  wire logic [hwb_pkg::PIX_W-1:0]   i_green_in,
    input  wire logic [hwb_pkg::PIX_W-1:0]   i_red_in,
    input  wire logic                        i_frame_end,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [hwb_pkg::PIX_W-1:0]   o_blue_out,
    output logic      [hwb_pkg::PIX_W-1:0]   o_green_out,
    output logic      [hwb_pkg::PIX_W-1:0]   o_red_out
);
    import hwb_pkg::*;

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_SWEEP = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;

    logic [2:0]         r_state;
    logic [RATIO_W-1:0] r_ratio;
    logic [CNT_W-1:0]   r_count;
    logic [BIN_W:0]     r_addr;
    logic               r_dv;
    logic [BIN_W-1:0]   r_daddr;
    logic [PIX_W-1:0]   r_px [NCH];
    logic               r_last;
    logic [THR_W-1:0]   r_lo_thr;
    logic [THR_W-1:0]   r_hi_thr;
    logic [PIX_W-1:0]   r_lo_cut [NCH];
    logic [PIX_W-1:0]   r_hi_cut [NCH];
    logic [2:0]         r_step;
    logic               r_div_end;
    logic               r_ov;
    logic [PIX_W-1:0]   r_out [NCH];

    logic               w_acc;
    logic               w_load;
    logic [PIX_W-1:0]   w_in_px [NCH];
    logic [BIN_W-1:0]   w_raddr [NCH];
    logic [BIN_W-1:0]   w_waddr [NCH];
    logic [CNT_W-1:0]   w_wdata [NCH];
    logic [CNT_W-1:0]   w_rdata [NCH];
    logic               w_we;
    logic [PIX_W-1:0]   w_lo [NCH];
    logic [PIX_W-1:0]   w_hi [NCH];
    logic [PIX_W-1:0]   w_q  [NCH];
    t_cut_ctl           w_cut_ctl;
    t_div_ctl           w_div_ctl;

    assign w_in_px[0] = i_blue_in;
    assign w_in_px[1] = i_green_in;
    assign w_in_px[2] = i_red_in;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_acc      = i_in_valid && (r_state == ST_IDLE);
    assign w_load     = (r_state == ST_DIV) && r_div_end && (!r_ov || !i_out_stall);

    assign w_we = (r_state == ST_ACC) || (r_state == ST_CLR)
               || ((r_state == ST_SWEEP) && r_dv);

    assign w_cut_ctl.clear   = (r_state == ST_MUL);
    assign w_cut_ctl.step    = (r_state == ST_SWEEP) && r_dv;
    assign w_cut_ctl.gate_lo = (r_daddr != LAST_BIN);

    assign w_div_ctl.start = w_acc && i_opcode;
    assign w_div_ctl.step  = (r_state == ST_DIV) && !r_div_end;
    assign w_div_ctl.shift = r_step;

    for (genvar c = 0; c < NCH; c++) begin : g_ch
        always_comb begin
            w_raddr[c] = (r_state == ST_SWEEP) ? r_addr[BIN_W-1:0] : w_in_px[c];
            if (r_state == ST_ACC) begin
                w_waddr[c] = r_px[c];
                w_wdata[c] = w_rdata[c] + 1'b1;
            end else if (r_state == ST_SWEEP) begin
                w_waddr[c] = r_daddr;
                w_wdata[c] = '0;
            end else begin
                w_waddr[c] = r_addr[BIN_W-1:0];
                w_wdata[c] = '0;
            end
        end

        hwb_ram #(
            .WIDTH (CNT_W),
            .DEPTH (BINS)
        ) u_hist (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (w_waddr[c]),
            .i_wdata (w_wdata[c]),
            .i_raddr (w_raddr[c]),
            .o_rdata (w_rdata[c])
        );

        hwb_cut u_cut (
            .i_clk    (i_clk),
            .i_ctl    (w_cut_ctl),
            .i_bin    (w_rdata[c]),
            .i_lo_thr (r_lo_thr),
            .i_hi_thr (r_hi_thr),
            .o_lo     (w_lo[c]),
            .o_hi     (w_hi[c])
        );

        hwb_div u_div (
            .i_clk (i_clk),
            .i_ctl (w_div_ctl),
            .i_pix (w_in_px[c]),
            .i_lo  (r_lo_cut[c]),
            .i_hi  (r_hi_cut[c]),
            .o_q   (w_q[c])
        );
    end

    // Pixel payload, threshold and output registers.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_px   <= w_in_px;
            r_last <= i_frame_end;
        end
        if (r_state == ST_MUL) begin
            r_lo_thr <= THR_W'(r_ratio) * THR_W'(r_count);
            r_hi_thr <= THR_W'(ONE_Q16 - SCALE_W'(r_ratio)) * THR_W'(r_count);
        end
        if (w_load) begin
            r_out <= w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_ratio   <= RATIO_RST;
            r_count   <= '0;
            r_addr    <= '0;
            r_dv      <= 1'b0;
            r_daddr   <= '0;
            r_step    <= '0;
            r_div_end <= 1'b0;
            r_ov      <= 1'b0;
            for (int c = 0; c < NCH; c++) begin
                r_lo_cut[c] <= '0;
                r_hi_cut[c] <= PIX_MAX;
            end
        end else begin
            if (i_cfg_we) begin
                r_ratio <= i_cfg_data;
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_CLR: begin
                    if (r_addr[BIN_W-1:0] == LAST_BIN) begin
                        r_addr  <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (w_acc) begin
                        if (i_opcode) begin
                            r_step    <= 3'd7;
                            r_div_end <= 1'b0;
                            r_state   <= ST_DIV;
                        end else if (r_count < MAX_COUNT) begin
                            r_state <= ST_ACC;
                        end else if (i_frame_end) begin
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_ACC: begin
                    r_count <= r_count + 1'b1;
                    r_state <= r_last ? ST_MUL : ST_IDLE;
                end
                ST_MUL: begin
                    r_addr  <= '0;
                    r_dv    <= 1'b0;
                    r_state <= ST_SWEEP;
                end
                ST_SWEEP: begin
                    // Bin data comes back in the cycle after its read, when r_daddr holds its address.
                    if (!r_addr[BIN_W]) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    r_dv    <= !r_addr[BIN_W];
                    r_daddr <= r_addr[BIN_W-1:0];
                    if (r_dv && (r_daddr == LAST_BIN)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_lo_cut <= w_lo;
                    r_hi_cut <= w_hi;
                    r_count  <= '0;
                    r_dv     <= 1'b0;
                    r_addr   <= '0;
                    r_state  <= ST_IDLE;
                end
                ST_DIV: begin
                    if (!r_div_end) begin
                        r_step <= r_step - 1'b1;
                        if (r_step == '0) begin
                            r_div_end <= 1'b1;
                        end
                    end else if (w_load) begin
                        r_div_end <= 1'b0;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_blue_out  = r_out[0];
    assign o_green_out = r_out[1];
    assign o_red_out   = r_out[2];

endmodule

`default_nettype wire

// ===== sv/hwb_ram.sv =====
// ----------------------------------------------------------------------------
// hwb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hwb_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/hwb_cut.sv =====
// ----------------------------------------------------------------------------
// hwb_cut
// Cut point search for one channel, fed one histogram bin per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hwb_cut (
    input  wire logic                      i_clk,
    input  wire hwb_pkg::t_cut_ctl         i_ctl,
    input  wire logic [hwb_pkg::CNT_W-1:0] i_bin,
    input  wire logic [hwb_pkg::THR_W-1:0] i_lo_thr,
    input  wire logic [hwb_pkg::THR_W-1:0] i_hi_thr,
    output logic      [hwb_pkg::PIX_W-1:0] o_lo,
    output logic      [hwb_pkg::PIX_W-1:0] o_hi
);
    import hwb_pkg::*;

    logic [CNT_W-1:0] r_run;
    logic [BIN_W-1:0] r_lo;
    logic [BIN_W:0]   r_k;
    logic [CNT_W-1:0] w_run;
    logic [THR_W-1:0] w_cum;
    logic [BIN_W-1:0] w_hi0;

    assign w_run = r_run + i_bin;
    assign w_cum = {1'b0, w_run, 16'h0000};

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_run <= '0;
            r_lo  <= '0;
            r_k   <= '0;
        end else if (i_ctl.step) begin
            r_run <= w_run;
            if (i_ctl.gate_lo && (w_cum < i_lo_thr)) begin
                r_lo <= r_lo + 1'b1;
            end
            // The high cut counts the bins at or below the threshold,
            // so it lands one below the first bin above it.
            if (!(w_cum > i_hi_thr)) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    always_comb begin
        w_hi0 = (r_k == '0) ? '0 : BIN_W'(r_k - 1'b1);
        o_lo  = r_lo;
        o_hi  = (w_hi0 < (PIX_MAX - 1'b1)) ? w_hi0 + 1'b1 : w_hi0;
    end

endmodule

`default_nettype wire

// ===== sv/hwb_div.sv =====
// ----------------------------------------------------------------------------
// hwb_div
// Clamp and stretch of one channel with a bit-serial restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module hwb_div (
    input  wire logic                      i_clk,
    input  wire hwb_pkg::t_div_ctl         i_ctl,
    input  wire logic [hwb_pkg::PIX_W-1:0] i_pix,
    input  wire logic [hwb_pkg::PIX_W-1:0] i_lo,
    input  wire logic [hwb_pkg::PIX_W-1:0] i_hi,
    output logic      [hwb_pkg::PIX_W-1:0] o_q
);
    import hwb_pkg::*;

    logic [2*PIX_W-1:0] r_rem;
    logic [PIX_W-1:0]   r_den;
    logic [PIX_W-1:0]   r_q;
    logic               r_sp;
    logic [PIX_W-1:0]   w_v;
    logic [PIX_W-1:0]   w_d;
    logic [2*PIX_W-1:0] w_sub;

    always_comb begin
        w_v = i_pix;
        if (w_v < i_lo) begin
            w_v = i_lo;
        end
        if (w_v > i_hi) begin
            w_v = i_hi;
        end
        w_d   = w_v - i_lo;
        w_sub = (2*PIX_W)'(r_den) << i_ctl.shift;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            // An inverted range gives full scale, an empty range gives zero.
            r_sp  <= (i_hi <= i_lo);
            r_q   <= (i_hi < i_lo) ? PIX_MAX : '0;
            r_rem <= {w_d, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, w_d};
            r_den <= i_hi - i_lo;
        end else if (i_ctl.step && !r_sp) begin
            if (r_rem >= w_sub) begin
                r_rem            <= r_rem - w_sub;
                r_q[i_ctl.shift] <= 1'b1;
            end
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ===== sv/hwb_check.sv =====
// ----------------------------------------------------------------------------
// hwb_check
// Port-level checks for the histogram white balance block.
// ----------------------------------------------------------------------------
`default_nettype none

module hwb_check (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_stall,
    input wire logic                        i_opcode,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [hwb_pkg::PIX_W-1:0]   o_blue_out,
    input wire logic [hwb_pkg::PIX_W-1:0]   o_green_out,
    input wire logic [hwb_pkg::PIX_W-1:0]   o_red_out
);

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A held result beat keeps its data.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_blue_out)
            && $stable(o_green_out) && $stable(o_red_out))
        else $error("stalled result changed");

    // A correct pixel occupies the divider, so the input stalls next cycle.
    a_corr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_opcode |=> o_in_stall)
        else $error("input not stalled during divide");

    // An accumulate pixel never produces a result beat.
    a_acc_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_opcode && !o_out_valid |=> !o_out_valid)
        else $error("result from accumulate pixel");

endmodule

bind histogram_white_balance hwb_check u_hwb_check (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for histogram_white_balance. It builds frames of
// accumulate pixels and streams correct pixels. A built-in model works out
// the cut points and the stretched outputs, and each output beat is checked.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    import hwb_pkg::*;

    localparam logic OP_ACCUM   = 1'b0;
    localparam logic OP_CORRECT = 1'b1;
    localparam int   LIMIT      = 600000;
    localparam int   DRAIN      = 300;
    localparam int   LONG_HOLD  = 600;
    localparam int   PHASE_LEN  = 200;

    typedef struct packed {
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] r;
    } pixel_t;

    typedef struct {
        logic   op;
        pixel_t px;
        logic   fe;
        logic   typed;
        pixel_t want;
    } vector_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [RATIO_W-1:0]   i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_opcode = 1'b0;
    logic [PIX_W-1:0]     i_blue_in = '0;
    logic [PIX_W-1:0]     i_green_in = '0;
    logic [PIX_W-1:0]     i_red_in = '0;
    logic                 i_frame_end = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b1;
    logic [PIX_W-1:0]     o_blue_out;
    logic [PIX_W-1:0]     o_green_out;
    logic [PIX_W-1:0]     o_red_out;

    histogram_white_balance uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_blue_in   (i_blue_in),
        .i_green_in  (i_green_in),
        .i_red_in    (i_red_in),
        .i_frame_end (i_frame_end),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_blue_out  (o_blue_out),
        .o_green_out (o_green_out),
        .o_red_out   (o_red_out)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Model state.
    int unsigned    bin_count [NCH][BINS];
    int unsigned    frame_pixels;
    int unsigned    cut_lo [NCH];
    int unsigned    cut_hi [NCH];
    int unsigned    ratio_q16;

    pixel_t         pending_pixels [$];
    int unsigned    errors = 0;
    int unsigned    beats_out = 0;
    int unsigned    cycles = 0;
    bit             hold_done = 1'b0;

    function automatic void clear_model();
        for (int ch = 0; ch < NCH; ch++) begin
            for (int b = 0; b < BINS; b++) begin
                bin_count[ch][b] = 0;
            end
            cut_lo[ch] = 0;
            cut_hi[ch] = 255;
        end
        frame_pixels = 0;
        ratio_q16 = 3277;
    endfunction

    function automatic void search_cuts();
        longint unsigned total;
        longint unsigned lo_thr;
        longint unsigned hi_thr;
        longint unsigned run;
        longint unsigned cum [BINS];
        int              lo;
        int              hi;
        total  = frame_pixels;
        lo_thr = longint'(ratio_q16) * total;
        hi_thr = longint'(65536 - ratio_q16) * total;
        for (int ch = 0; ch < NCH; ch++) begin
            run = 0;
            for (int b = 0; b < BINS; b++) begin
                run += bin_count[ch][b];
                cum[b] = run;
            end
            lo = 0;
            while (lo < 255 && (cum[lo] << 16) < lo_thr) lo++;
            hi = 255;
            while (hi > 0 && (cum[hi] << 16) > hi_thr) hi--;
            if (hi < 254) hi++;
            cut_lo[ch] = lo;
            cut_hi[ch] = hi;
        end
    endfunction

    function automatic logic [PIX_W-1:0] stretch_sample(int ch, int unsigned v);
        int unsigned lo;
        int unsigned hi;
        lo = cut_lo[ch];
        hi = cut_hi[ch];
        if (hi < lo) return 8'd255;
        if (hi == lo) return 8'd0;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return PIX_W'(((v - lo) * 255) / (hi - lo));
    endfunction

    // Updates the model for one accepted pixel; returns 1 when a beat is due.
    function automatic bit apply_pixel(logic op, pixel_t px, logic fe, output pixel_t res);
        int unsigned v [NCH];
        v[0] = px.b;
        v[1] = px.g;
        v[2] = px.r;
        res = '0;
        if (op == OP_ACCUM) begin
            if (frame_pixels < MAX_PIXELS) begin
                for (int ch = 0; ch < NCH; ch++) bin_count[ch][v[ch]]++;
                frame_pixels++;
            end
            if (fe) begin
                search_cuts();
                for (int ch = 0; ch < NCH; ch++) begin
                    for (int b = 0; b < BINS; b++) bin_count[ch][b] = 0;
                end
                frame_pixels = 0;
            end
            return 1'b0;
        end
        res.b = stretch_sample(0, v[0]);
        res.g = stretch_sample(1, v[1]);
        res.r = stretch_sample(2, v[2]);
        return 1'b1;
    endfunction

    function automatic int draw_gap();
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
    endfunction

    // Offers one pixel and returns once it has been accepted.
    task automatic send_pixel(logic op, pixel_t px, logic fe, logic typed, pixel_t want);
        int     gap;
        pixel_t res;
        gap = draw_gap();
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_blue_in   <= px.b;
        i_green_in  <= px.g;
        i_red_in    <= px.r;
        i_frame_end <= fe;
        do @(posedge i_clk); while (o_in_stall);
        if (apply_pixel(op, px, fe, res)) pending_pixels.push_back(typed ? want : res);
    endtask

    task automatic write_ratio(logic [RATIO_W-1:0] value);
        @(negedge i_clk) i_in_valid <= 1'b0;
        wait (pending_pixels.size() == 0);
        // A frame end may still be scanning the bins with no beat to show for it.
        repeat (DRAIN) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk) i_cfg_we <= 1'b0;
        ratio_q16 = value;
    endtask

    function automatic logic [PIX_W-1:0] spread_sample(bit narrow, int base, int width);
        return narrow ? PIX_W'(base + $urandom_range(0, width)) : PIX_W'($urandom_range(0, 255));
    endfunction

    task automatic random_phase(int n_items);
        int     sent;
        int     n_acc;
        int     n_cor;
        bit     narrow;
        int     base [NCH];
        int     width;
        pixel_t px;
        sent = 0;
        while (sent < n_items) begin
            n_acc  = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
            narrow = $urandom_range(0, 1);
            width  = $urandom_range(0, 20);
            for (int ch = 0; ch < NCH; ch++) base[ch] = $urandom_range(0, 255);
            for (int k = 0; k < n_acc; k++) begin
                px.b = spread_sample(narrow, base[0], width);
                px.g = spread_sample(narrow, base[1], width);
                px.r = spread_sample(narrow, base[2], width);
                send_pixel(OP_ACCUM, px, k == n_acc - 1, 1'b0, '0);
            end
            n_cor = $urandom_range(1, 30);
            for (int k = 0; k < n_cor; k++) begin
                px = pixel_t'(24'($urandom()));
                send_pixel(OP_CORRECT, px, $urandom_range(0, 15) == 0, 1'b0, '0);
            end
            sent += n_acc + n_cor;
        end
    endtask

    vector_t directed [$];

    function automatic vector_t row(logic op, pixel_t px, logic fe, logic typed, pixel_t want);
        vector_t t;
        t.op    = op;
        t.px    = px;
        t.fe    = fe;
        t.typed = typed;
        t.want  = want;
        return t;
    endfunction

    initial begin
        clear_model();
        // After reset the cuts span the full range, so outputs equal inputs.
        directed.push_back(row(OP_CORRECT, '{8'd0, 8'd128, 8'd255}, 1'b0, 1'b1,
                               '{8'd0, 8'd128, 8'd255}));
        directed.push_back(row(OP_CORRECT, '{8'd255, 8'd0, 8'd1}, 1'b1, 1'b1,
                               '{8'd255, 8'd0, 8'd1}));
        // A flat frame gives equal cuts, and every output of the frame is zero.
        for (int k = 0; k < 4; k++) begin
            directed.push_back(row(OP_ACCUM, '{8'd100, 8'd50, 8'd200}, k == 3, 1'b0, '0));
        end
        directed.push_back(row(OP_CORRECT, '{8'd0, 8'd255, 8'd100}, 1'b0, 1'b1,
                               '{8'd0, 8'd0, 8'd0}));
        directed.push_back(row(OP_CORRECT, '{8'd255, 8'd0, 8'd200}, 1'b0, 1'b1,
                               '{8'd0, 8'd0, 8'd0}));
        // Frame made of the two extremes.
        for (int k = 0; k < 8; k++) begin
            directed.push_back(row(OP_ACCUM, k[0] ? pixel_t'{8'd255, 8'd0, 8'd255} :
                                   pixel_t'{8'd0, 8'd255, 8'd0}, k == 7, 1'b0, '0));
        end
        directed.push_back(row(OP_CORRECT, '{8'd0, 8'd0, 8'd0}, 1'b0, 1'b0, '0));
        directed.push_back(row(OP_CORRECT, '{8'd255, 8'd255, 8'd255}, 1'b0, 1'b0, '0));
        directed.push_back(row(OP_CORRECT, '{8'd127, 8'd128, 8'd1}, 1'b1, 1'b0, '0));
        // Single-pixel frame.
        directed.push_back(row(OP_ACCUM, '{8'd7, 8'd250, 8'd128}, 1'b1, 1'b0, '0));
        directed.push_back(row(OP_CORRECT, '{8'd6, 8'd251, 8'd128}, 1'b0, 1'b0, '0));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            send_pixel(directed[i].op, directed[i].px, directed[i].fe,
                       directed[i].typed, directed[i].want);
        end

        write_ratio(RATIO_W'(0));
        random_phase(PHASE_LEN);
        write_ratio(RATIO_W'(32767));
        random_phase(PHASE_LEN);
        write_ratio(RATIO_W'($urandom_range(1, 32766)));
        random_phase(PHASE_LEN);
        write_ratio(RATIO_RST);
        random_phase(PHASE_LEN);

        @(negedge i_clk) i_in_valid <= 1'b0;
        wait (pending_pixels.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0) begin
            $display("histogram_white_balance: match");
        end else begin
            $display("histogram_white_balance: mismatch");
        end
        $finish;
    end

    // Output side: random stall per beat, plus one long hold so the input backs up.
    initial begin
        int n;
        wait (i_rst_n);
        forever begin
            n = draw_gap();
            if (!hold_done && beats_out >= 40) begin
                n = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (n > 0) begin
                @(negedge i_clk) i_out_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end
            @(negedge i_clk) i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        pixel_t got;
        pixel_t want;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("histogram_white_balance: mismatch");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            beats_out <= beats_out + 1;
            got = '{o_blue_out, o_green_out, o_red_out};
            if (pending_pixels.size() == 0) begin
                if (errors < 10) $display("unexpected output beat b=%0d g=%0d r=%0d",
                                          got.b, got.g, got.r);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                if (got !== want) begin
                    if (errors < 10) begin
                        $display("beat %0d: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                                 beats_out, want.b, want.g, want.r, got.b, got.g, got.r);
                    end
                    errors++;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== files.f =====
sv/hwb_pkg.sv
sv/hwb_ram.sv
sv/hwb_cut.sv
sv/hwb_div.sv
sv/histogram_white_balance.sv
sv/hwb_check.sv
tb/testbench.sv
